### rtl/core/yuvrgb_pkg.sv
package yuvrgb_pkg;

    // Register map: one 32-bit register, byte address = 4 * index
    localparam int PADDR_W = 3;
    localparam logic REG_FORMAT = 1'b0;

    // Input format codes
    typedef enum logic [1:0] {
        FMT_YUYV  = 2'd0,
        FMT_UYVY  = 2'd1,
        FMT_MONO  = 2'd2,
        FMT_CLASS = 2'd3
    } fmt_t;

    // One input item: a four-byte group
    typedef struct packed {
        logic [7:0] byte_0;
        logic [7:0] byte_1;
        logic [7:0] byte_2;
        logic [7:0] byte_3;
    } in_item_t;

    // One result item: an RGB pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } out_item_t;

    // One pixel request handed from the serializer to the math pipeline
    typedef struct packed {
        logic        direct;   // rgb is final, skip the YUV math
        logic [7:0]  y;
        logic [7:0]  u;
        logic [7:0]  v;
        logic [23:0] rgb;      // {r, g, b} for direct pixels
        logic        last;
    } pix_req_t;

    // Fixed point coefficients, scaled by 4096
    localparam logic signed [14:0] K_B   = 15'sd8308;
    localparam logic signed [13:0] K_R   = 14'sd4670;
    localparam logic        [12:0] K_GY  = 13'd6963;
    localparam logic signed [13:0] K_GR  = 14'sd2085;
    localparam logic signed [10:0] K_GB  = 11'sd795;
    localparam logic signed [8:0]  C_MID = 9'sd128;
    localparam logic signed [10:0] P_MAX = 11'sd255;

    // Class palette, {r, g, b}; out of range codes give black
    function automatic logic [23:0] palette_rgb(input logic [7:0] code);
        logic [23:0] rgb;
        case (code)
            8'd0:    rgb = 24'hFF0000;
            8'd1:    rgb = 24'h00FF00;
            8'd2:    rgb = 24'h0000FF;
            8'd3:    rgb = 24'h00FFFF;
            8'd4:    rgb = 24'hFF00FF;
            8'd5:    rgb = 24'hFFFF00;
            8'd6:    rgb = 24'hFFFFFF;
            default: rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

endpackage

### rtl/core/packed_yuv_to_rgb_converter.sv
// Packed YUV 4:2:2 / mono / class to RGB888 converter.
//
// Input channel (group_valid/group_ready/group): one four-byte item per
// handshake. In YUYV and UYVY modes an item gives two RGB pixels, the second
// flagged with last_pixel. In mono and class modes byte_0 gives one pixel.
// Output channel (pixel_valid/pixel_ready/pixel): one RGB pixel per cycle
// while pixel_ready is high. The format register sits at byte address 0 of
// the APB port; write it only while no item is in flight.
// Each accepted item waits in the serializer's holding register; its pixel
// requests then pass through the four-stage datapath, the second right behind
// the first. Throughput: one mono or class item every cycle while the receiver
// does not stall; a YUV item holds the serializer until both requests go out.
// Reset clears the format to YUYV and empties the pipeline.
// When the receiver stalls, the whole datapath holds; the input keeps
// taking items until the serializer's holding register is full.
module packed_yuv_to_rgb_converter (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [yuvrgb_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // Input channel
    input  logic                                group_valid,
    output logic                                group_ready,
    input  yuvrgb_pkg::in_item_t                group,
    // Output channel
    output logic                                pixel_valid,
    input  logic                                pixel_ready,
    output yuvrgb_pkg::out_item_t               pixel
);

    yuvrgb_pkg::fmt_t     fmt_reg, fmt_next;
    yuvrgb_pkg::in_item_t hold_reg, hold_next;
    yuvrgb_pkg::fmt_t     hmode_reg, hmode_next;
    logic                 hvalid_reg, hvalid_next;
    logic                 phase_reg, phase_next;

    logic                 en;
    logic                 finishing;
    logic                 take;
    logic                 emit;
    logic                 cfg_wr;
    logic                 out_valid;
    yuvrgb_pkg::pix_req_t req;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == yuvrgb_pkg::REG_FORMAT);

    always_comb
    begin
        fmt_next = fmt_reg;
        if (cfg_wr)
            fmt_next = yuvrgb_pkg::fmt_t'(pwdata[1:0]);
    end

    always_comb
    begin
        if (paddr[2] == yuvrgb_pkg::REG_FORMAT)
            prdata = {30'b0, fmt_reg};
        else
            prdata = '0;
    end

    // Handshake and pipeline advance
    assign en          = !out_valid || pixel_ready;
    assign finishing   = hmode_reg[1] || phase_reg;
    assign emit        = hvalid_reg && en;
    assign group_ready = !hvalid_reg || (en && finishing);
    assign take        = group_valid && group_ready;

    // Serializer: build one pixel request per cycle from the held item while en is high
    always_comb
    begin
        req.direct = 1'b0;
        req.y      = hold_reg.byte_0;
        req.u      = hold_reg.byte_1;
        req.v      = hold_reg.byte_3;
        req.rgb    = '0;
        req.last   = finishing;
        case (hmode_reg)
            yuvrgb_pkg::FMT_YUYV:
            begin
                req.y = phase_reg ? hold_reg.byte_2 : hold_reg.byte_0;
                req.u = hold_reg.byte_1;
                req.v = hold_reg.byte_3;
            end
            yuvrgb_pkg::FMT_UYVY:
            begin
                req.y = phase_reg ? hold_reg.byte_3 : hold_reg.byte_1;
                req.u = hold_reg.byte_0;
                req.v = hold_reg.byte_2;
            end
            yuvrgb_pkg::FMT_MONO:
            begin
                req.direct = 1'b1;
                req.rgb    = {hold_reg.byte_0, hold_reg.byte_0, hold_reg.byte_0};
            end
            default:
            begin
                req.direct = 1'b1;
                req.rgb    = yuvrgb_pkg::palette_rgb(hold_reg.byte_0);
            end
        endcase
    end

    // Holding register next state
    always_comb
    begin
        hold_next   = hold_reg;
        hmode_next  = hmode_reg;
        hvalid_next = hvalid_reg;
        phase_next  = phase_reg;
        if (take)
        begin
            hold_next   = group;
            hmode_next  = fmt_reg;
            hvalid_next = 1'b1;
            phase_next  = 1'b0;
        end
        else if (emit)
        begin
            if (finishing)
                hvalid_next = 1'b0;
            else
                phase_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= yuvrgb_pkg::FMT_YUYV;
            hvalid_reg <= 1'b0;
            phase_reg  <= 1'b0;
            hmode_reg  <= yuvrgb_pkg::FMT_YUYV;
        end
        else
        begin
            fmt_reg    <= fmt_next;
            hvalid_reg <= hvalid_next;
            phase_reg  <= phase_next;
            hmode_reg  <= hmode_next;
        end
    end

    // Held item payload
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    // Color math pipeline
    yuvrgb_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .req_valid (hvalid_reg),
        .req       (req),
        .out_valid (out_valid),
        .out_item  (pixel)
    );

    assign pixel_valid = out_valid;

endmodule

### rtl/core/yuvrgb_pipe.sv
// Four-stage YUV to RGB datapath; all stages advance together on en.
module yuvrgb_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 req_valid,
    input  yuvrgb_pkg::pix_req_t req,
    output logic                 out_valid,
    output yuvrgb_pkg::out_item_t out_item
);

    // Signed divide by 4096, truncating toward zero
    function automatic logic signed [10:0] div4096(input logic signed [23:0] x);
        logic signed [23:0] t;
        t = x[23] ? (x + 24'sd4095) : x;
        return t[22:12];
    endfunction

    // Clamp to 0..255
    function automatic logic [7:0] clamp8(input logic signed [10:0] v);
        logic [7:0] c;
        if (v[10])
            c = 8'd0;
        else if (v > yuvrgb_pkg::P_MAX)
            c = 8'hFF;
        else
            c = v[7:0];
        return c;
    endfunction

    // Valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // Stage 1: chroma products
    logic signed [21:0] pb1_reg, pr1_reg;
    logic [7:0]         y1_reg;
    logic               dir1_reg, last1_reg;
    logic [23:0]        rgb1_reg;

    // Stage 2: unclamped b and r
    logic signed [10:0] b2_reg, r2_reg;
    logic [7:0]         y2_reg;
    logic               dir2_reg, last2_reg;
    logic [23:0]        rgb2_reg;

    // Stage 3: green products
    logic [20:0]        gy3_reg;
    logic signed [20:0] gr3_reg;
    logic signed [19:0] gb3_reg;
    logic signed [10:0] b3_reg, r3_reg;
    logic               dir3_reg, last3_reg;
    logic [23:0]        rgb3_reg;

    // Stage 4: output register
    yuvrgb_pkg::out_item_t out_reg;

    logic signed [8:0]  du, dv;
    logic signed [23:0] pb_next, pr_next;
    logic signed [23:0] numb, numr, numg;
    logic signed [10:0] b_next, r_next, g_next;
    logic [20:0]        gy_next;
    logic signed [20:0] gr_next;
    logic signed [19:0] gb_next;
    yuvrgb_pkg::out_item_t out_next;

    // Stage 1 math
    always_comb
    begin
        du      = $signed({1'b0, req.u}) - yuvrgb_pkg::C_MID;
        dv      = $signed({1'b0, req.v}) - yuvrgb_pkg::C_MID;
        pb_next = du * yuvrgb_pkg::K_B;
        pr_next = dv * yuvrgb_pkg::K_R;
    end

    // Stage 2 math
    always_comb
    begin
        numb   = $signed({4'b0, y1_reg, 12'b0}) + 24'(pb1_reg);
        numr   = $signed({4'b0, y1_reg, 12'b0}) + 24'(pr1_reg);
        b_next = div4096(numb);
        r_next = div4096(numr);
    end

    // Stage 3 math
    always_comb
    begin
        gy_next = y2_reg * yuvrgb_pkg::K_GY;
        gr_next = r2_reg * yuvrgb_pkg::K_GR;
        gb_next = b2_reg * yuvrgb_pkg::K_GB;
    end

    // Stage 4 math: green sum, truncate, clamp, or pass a direct pixel
    always_comb
    begin
        numg   = $signed({3'b0, gy3_reg}) - 24'(gr3_reg) - 24'(gb3_reg);
        g_next = div4096(numg);
        if (dir3_reg)
        begin
            out_next.red   = rgb3_reg[23:16];
            out_next.green = rgb3_reg[15:8];
            out_next.blue  = rgb3_reg[7:0];
        end
        else
        begin
            out_next.red   = clamp8(r3_reg);
            out_next.green = clamp8(g_next);
            out_next.blue  = clamp8(b3_reg);
        end
        out_next.last_pixel = last3_reg;
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= req_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pb1_reg   <= pb_next[21:0];
            pr1_reg   <= pr_next[21:0];
            y1_reg    <= req.y;
            dir1_reg  <= req.direct;
            last1_reg <= req.last;
            rgb1_reg  <= req.rgb;

            b2_reg    <= b_next;
            r2_reg    <= r_next;
            y2_reg    <= y1_reg;
            dir2_reg  <= dir1_reg;
            last2_reg <= last1_reg;
            rgb2_reg  <= rgb1_reg;

            gy3_reg   <= gy_next;
            gr3_reg   <= gr_next;
            gb3_reg   <= gb_next;
            b3_reg    <= b2_reg;
            r3_reg    <= r2_reg;
            dir3_reg  <= dir2_reg;
            last3_reg <= last2_reg;
            rgb3_reg  <= rgb2_reg;

            out_reg   <= out_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_item  = out_reg;

endmodule

### rtl/core/yuvrgb_checker.sv
// Port-level checks for the converter
module yuvrgb_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  group_ready,
    input logic                  pixel_valid,
    input logic                  pixel_ready,
    input yuvrgb_pkg::out_item_t pixel
);

    // A stalled pixel holds its value
    a_pixel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel))
        else $error("stalled pixel changed or dropped");

    // The second pixel of a pair follows the first without a gap
    a_pair_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready && !pixel.last_pixel
        |=> pixel_valid && pixel.last_pixel)
        else $error("second pixel of a pair missing");

    // Input back-pressure held in consecutive cycles needs an output stall in one of them
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !group_ready && $past(!group_ready)
        |-> (pixel_valid && !pixel_ready) || $past(pixel_valid && !pixel_ready))
        else $error("input held off without an output stall");

endmodule

bind packed_yuv_to_rgb_converter yuvrgb_checker u_yuvrgb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .group_ready (group_ready),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel)
);

### bench/yuv_pixel_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the config port, predicts every RGB pixel
// from the accepted groups and the tracked format, and compares in order.
module yuv_pixel_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [yuvrgb_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    input  logic [31:0]                      prdata,
    input  logic                             pready,
    input  logic                             group_valid,
    input  logic                             group_ready,
    input  yuvrgb_pkg::in_item_t             group,
    input  logic                             pixel_valid,
    input  logic                             pixel_ready,
    input  yuvrgb_pkg::out_item_t            pixel,
    output int                               mismatches,
    output int                               pending,
    output int                               pixels_checked
);

    // Conversion coefficients, 4096 = 1.0
    localparam int SCALE       = 4096;
    localparam int B_PER_U     = 8308;
    localparam int R_PER_V     = 4670;
    localparam int G_PER_Y     = 6963;
    localparam int G_PER_R     = 2085;
    localparam int G_PER_B     = 795;
    localparam int CHROMA_ZERO = 128;
    localparam int AW          = yuvrgb_pkg::PADDR_W;

    yuvrgb_pkg::out_item_t expected_pixels[$];
    yuvrgb_pkg::fmt_t      fmt_shadow = yuvrgb_pkg::FMT_YUYV;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic logic [7:0] clamp_u8(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // One pixel from luma and the shared chroma pair; green uses unclamped r, b
    function automatic yuvrgb_pkg::out_item_t yuv_pixel(input int y, input int u,
                                                        input int v, input logic last);
        int                    du;
        int                    dv;
        int                    r;
        int                    g;
        int                    b;
        yuvrgb_pkg::out_item_t p;
        du = u - CHROMA_ZERO;
        dv = v - CHROMA_ZERO;
        b = (SCALE * y + B_PER_U * du) / SCALE;
        r = (SCALE * y + R_PER_V * dv) / SCALE;
        g = (G_PER_Y * y - G_PER_R * r - G_PER_B * b) / SCALE;
        p.red        = clamp_u8(r);
        p.green      = clamp_u8(g);
        p.blue       = clamp_u8(b);
        p.last_pixel = last;
        return p;
    endfunction

    function automatic logic [23:0] class_color(input logic [7:0] code);
        case (code)
            8'd0:    return {8'd255, 8'd0,   8'd0};
            8'd1:    return {8'd0,   8'd255, 8'd0};
            8'd2:    return {8'd0,   8'd0,   8'd255};
            8'd3:    return {8'd0,   8'd255, 8'd255};
            8'd4:    return {8'd255, 8'd0,   8'd255};
            8'd5:    return {8'd255, 8'd255, 8'd0};
            8'd6:    return {8'd255, 8'd255, 8'd255};
            default: return 24'd0;
        endcase
    endfunction

    // Queue the pixels one accepted group turns into
    task automatic predict_pixels(input yuvrgb_pkg::in_item_t g);
        yuvrgb_pkg::out_item_t p;
        case (fmt_shadow)
            yuvrgb_pkg::FMT_YUYV:
            begin
                expected_pixels.push_back(yuv_pixel(g.byte_0, g.byte_1, g.byte_3, 1'b0));
                expected_pixels.push_back(yuv_pixel(g.byte_2, g.byte_1, g.byte_3, 1'b1));
            end
            yuvrgb_pkg::FMT_UYVY:
            begin
                expected_pixels.push_back(yuv_pixel(g.byte_1, g.byte_0, g.byte_2, 1'b0));
                expected_pixels.push_back(yuv_pixel(g.byte_3, g.byte_0, g.byte_2, 1'b1));
            end
            yuvrgb_pkg::FMT_MONO:
            begin
                p = '{red: g.byte_0, green: g.byte_0, blue: g.byte_0, last_pixel: 1'b1};
                expected_pixels.push_back(p);
            end
            default:
            begin
                {p.red, p.green, p.blue} = class_color(g.byte_0);
                p.last_pixel = 1'b1;
                expected_pixels.push_back(p);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        yuvrgb_pkg::out_item_t want;
        if (!rst_n)
        begin
            expected_pixels.delete();
            fmt_shadow = yuvrgb_pkg::FMT_YUYV;
            pending <= 0;
        end
        else
        begin
            // Output side: compare against the oldest prediction
            if (pixel_valid && pixel_ready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch($sformatf("unexpected pixel %h", pixel));
                else
                begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (pixel.red !== want.red)
                        report_mismatch($sformatf("red %h, want %h", pixel.red, want.red));
                    if (pixel.green !== want.green)
                        report_mismatch($sformatf("green %h, want %h",
                                                  pixel.green, want.green));
                    if (pixel.blue !== want.blue)
                        report_mismatch($sformatf("blue %h, want %h", pixel.blue, want.blue));
                    if (pixel.last_pixel !== want.last_pixel)
                        report_mismatch($sformatf("last_pixel %b, want %b",
                                                  pixel.last_pixel, want.last_pixel));
                end
            end

            // Input side: predict with the format in force before this edge
            if (group_valid && group_ready)
                predict_pixels(group);

            // Config port: only the format register exists
            if (psel && penable && pready && (paddr >> 2) == AW'(yuvrgb_pkg::REG_FORMAT))
            begin
                if (pwrite)
                    fmt_shadow = yuvrgb_pkg::fmt_t'(pwdata[1:0]);
                else if (prdata !== {30'd0, fmt_shadow})
                    report_mismatch($sformatf("format readback %h, want %0d",
                                              prdata, fmt_shadow));
            end

            pending <= expected_pixels.size();
        end
    end

endmodule

### bench/tb_packed_yuv_to_rgb_converter.sv
`timescale 1ns / 1ps

module tb_packed_yuv_to_rgb_converter;

    localparam int            AW            = yuvrgb_pkg::PADDR_W;
    localparam int            GROUP_TARGET  = 1450;
    localparam int            HOLD_CYCLES   = 300;
    localparam logic [AW-1:0] FORMAT_ADDR   = AW'(4 * yuvrgb_pkg::REG_FORMAT);
    localparam logic [AW-1:0] UNMAPPED_ADDR = AW'(4);

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [AW-1:0]         paddr       = '0;
    logic [31:0]           pwdata      = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  group_valid = 1'b0;
    logic                  group_ready;
    yuvrgb_pkg::in_item_t  group       = '0;
    logic                  pixel_valid;
    logic                  pixel_ready = 1'b0;
    yuvrgb_pkg::out_item_t pixel;

    int   mismatches;
    int   pending;
    int   pixels_checked;

    // Stimulus controls; rx_steady and rx_hold_cycles are shared with the output-side process
    bit               tx_steady      = 1'b0;
    bit               rx_steady      = 1'b0;
    int               rx_hold_cycles = 0;
    yuvrgb_pkg::fmt_t cur_fmt        = yuvrgb_pkg::FMT_YUYV;
    int               sent_per_fmt[4];
    int               groups_sent    = 0;

    packed_yuv_to_rgb_converter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .group_valid (group_valid),
        .group_ready (group_ready),
        .group       (group),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel)
    );

    yuv_pixel_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .group_valid    (group_valid),
        .group_ready    (group_ready),
        .group          (group),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .pixel          (pixel),
        .mismatches     (mismatches),
        .pending        (pending),
        .pixels_checked (pixels_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("timeout: groups sent %0d, pixels outstanding %0d", groups_sent, pending);
        $display("TB_ERROR");
        $finish;
    end

    // Pixel receiver: random stalls, steady stretches, and long hold-offs
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                pixel_ready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (rx_steady)
                pixel_ready <= 1'b1;
            else
                pixel_ready <= ($urandom_range(99) >= 16);
        end
    end

    // Byte with extra weight on the range ends
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    // Lay out two luma samples and a chroma pair for the active YUV order
    function automatic yuvrgb_pkg::in_item_t yuv_group(input yuvrgb_pkg::fmt_t f,
                                                       input logic [7:0] y1,
                                                       input logic [7:0] y2,
                                                       input logic [7:0] u,
                                                       input logic [7:0] v);
        yuvrgb_pkg::in_item_t g;
        if (f == yuvrgb_pkg::FMT_UYVY)
            g = '{byte_0: u, byte_1: y1, byte_2: v, byte_3: y2};
        else
            g = '{byte_0: y1, byte_1: u, byte_2: y2, byte_3: v};
        return g;
    endfunction

    task automatic send_group(input yuvrgb_pkg::in_item_t g);
        while (!tx_steady && $urandom_range(99) < 16)
        begin
            @(negedge clk);
            group_valid <= 1'b0;
            group       <= yuvrgb_pkg::in_item_t'($urandom());
        end
        @(negedge clk);
        group_valid <= 1'b1;
        group       <= g;
        @(posedge clk);
        while (!group_ready)
            @(posedge clk);
        sent_per_fmt[cur_fmt]++;
        groups_sent++;
    endtask

    task automatic apb_access(input logic wr, input logic [AW-1:0] addr,
                              input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Let everything in flight come out before touching the config
    task automatic drain_pipe();
        @(negedge clk);
        group_valid <= 1'b0;
        wait (pending == 0);
        repeat (6) @(posedge clk);
    endtask

    // Change format while idle; junk in the upper data bits must be dropped
    task automatic set_format(input yuvrgb_pkg::fmt_t f);
        logic [31:0] data;
        drain_pipe();
        data = $urandom();
        data[1:0] = f;
        apb_access(1'b1, FORMAT_ADDR, data);
        apb_access(1'b0, FORMAT_ADDR, 32'd0);
        cur_fmt = f;
    endtask

    initial
    begin
        yuvrgb_pkg::in_item_t g;
        int                   n_items;
        int                   phase;
        int                   guard;
        int                   leftover;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset value of the format register
        apb_access(1'b0, FORMAT_ADDR, 32'd0);

        // Directed YUYV: range corners and neutral chroma
        set_format(yuvrgb_pkg::FMT_YUYV);
        send_group(yuv_group(cur_fmt, 8'h00, 8'h00, 8'h00, 8'h00));
        send_group(yuv_group(cur_fmt, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_group(yuv_group(cur_fmt, 8'hFF, 8'h00, 8'h00, 8'h00));
        send_group(yuv_group(cur_fmt, 8'h00, 8'hFF, 8'hFF, 8'h00));
        send_group(yuv_group(cur_fmt, 8'h80, 8'h80, 8'h80, 8'h80));
        send_group(yuv_group(cur_fmt, 8'hFF, 8'h00, 8'h00, 8'hFF));

        // Directed UYVY
        set_format(yuvrgb_pkg::FMT_UYVY);
        send_group(yuv_group(cur_fmt, 8'h00, 8'hFF, 8'h00, 8'hFF));
        send_group(yuv_group(cur_fmt, 8'hFF, 8'h00, 8'hFF, 8'h00));
        send_group(yuv_group(cur_fmt, 8'h10, 8'hEB, 8'h80, 8'h80));
        send_group(yuvrgb_pkg::in_item_t'($urandom()));

        // Mono: only byte_0 counts
        set_format(yuvrgb_pkg::FMT_MONO);
        for (int k = 0; k < 3; k++)
        begin
            g = yuvrgb_pkg::in_item_t'($urandom());
            g.byte_0 = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'hA5;
            send_group(g);
        end

        // Class: every palette entry, first and last out-of-range codes
        set_format(yuvrgb_pkg::FMT_CLASS);
        for (int c = 0; c < 9; c++)
        begin
            g = yuvrgb_pkg::in_item_t'($urandom());
            g.byte_0 = (c == 8) ? 8'hFF : 8'(c);
            send_group(g);
        end

        // Write to an unmapped index must leave the format alone
        drain_pipe();
        apb_access(1'b1, UNMAPPED_ADDR, $urandom());
        apb_access(1'b0, FORMAT_ADDR, 32'd0);
        g = yuvrgb_pkg::in_item_t'($urandom());
        g.byte_0 = 8'd3;
        send_group(g);

        // Random phases, each under one format
        phase = 0;
        while (groups_sent < GROUP_TARGET)
        begin
            set_format((phase < 4) ? yuvrgb_pkg::fmt_t'(phase)
                                   : yuvrgb_pkg::fmt_t'($urandom_range(3)));
            n_items = $urandom_range(60, 140);
            if (n_items > GROUP_TARGET - groups_sent)
                n_items = GROUP_TARGET - groups_sent;
            tx_steady = (phase == 5);
            rx_steady = (phase == 5);
            for (int k = 0; k < n_items; k++)
            begin
                // Output blocked for a long time while groups keep coming
                if (phase == 2 && k == 10)
                    rx_hold_cycles = HOLD_CYCLES;
                // Sender stops until every pixel is out
                if (phase == 6 && k == n_items / 2)
                begin
                    @(negedge clk);
                    group_valid <= 1'b0;
                    wait (pending == 0);
                end
                case (cur_fmt)
                    yuvrgb_pkg::FMT_YUYV, yuvrgb_pkg::FMT_UYVY:
                        g = yuv_group(cur_fmt, pick_byte(), pick_byte(), pick_byte(),
                                      pick_byte());
                    yuvrgb_pkg::FMT_MONO:
                    begin
                        g = yuvrgb_pkg::in_item_t'($urandom());
                        g.byte_0 = pick_byte();
                    end
                    default:
                    begin
                        g = yuvrgb_pkg::in_item_t'($urandom());
                        g.byte_0 = ($urandom_range(3) == 0) ? 8'($urandom())
                                                            : 8'($urandom_range(9));
                    end
                endcase
                send_group(g);
            end
            tx_steady = 1'b0;
            rx_steady = 1'b0;
            phase++;
        end

        // Final drain, bounded, then watch for stray pixels
        @(negedge clk);
        group_valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        leftover = pending;
        repeat (20) @(posedge clk);
        if (leftover != 0)
            $display("%0d expected pixels never arrived", leftover);

        $display("Covered %0d groups (YUYV %0d, UYVY %0d, mono %0d, class %0d), %0d pixels.",
                 groups_sent, sent_per_fmt[yuvrgb_pkg::FMT_YUYV],
                 sent_per_fmt[yuvrgb_pkg::FMT_UYVY], sent_per_fmt[yuvrgb_pkg::FMT_MONO],
                 sent_per_fmt[yuvrgb_pkg::FMT_CLASS], pixels_checked);
        $display("Included a %0d-cycle output hold-off, a full drain pause, a stall-free run.",
                 HOLD_CYCLES);
        if (mismatches == 0 && leftover == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
rtl/core/yuvrgb_pkg.sv
rtl/core/yuvrgb_pipe.sv
rtl/core/packed_yuv_to_rgb_converter.sv
rtl/core/yuvrgb_checker.sv
bench/yuv_pixel_checker.sv
bench/tb_packed_yuv_to_rgb_converter.sv
